>>> src/adp_pkg.sv
// Shared constants, types and codes of the Adam parameter update engine.
`default_nettype none
package adp_pkg;

  localparam int ELEMENTS     = 4096;  // moment store depth, a power of two
  localparam int IDX_W        = $clog2(ELEMENTS);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 24;
  localparam int IN_DATA_W    = 80;
  localparam int OUT_DATA_W   = 48;

  // Pipeline depths of the scaling unit
  localparam int DIV_STAGES   = 16;  // 2 bits of m_hat, 4 bits of v_hat per stage
  localparam int SQRT_STAGES  = 16;  // 2 root bits per stage
  localparam int QUO_STAGES   = 17;  // 2 update bits per stage

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef enum logic {
    FUNC_STEP = 1'b0,
    FUNC_ELEM = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE   = 8'd0,
    REG_DECAY_FIRST  = 8'd1,
    REG_DECAY_SECOND = 8'd2,
    REG_EPSILON      = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] learn_rate;
    logic [15:0] decay_first;
    logic [15:0] decay_second;
    logic [15:0] epsilon_term;
  } cfg_t;

  // Element item as queued between front and back
  typedef struct packed {
    logic [11:0] elem_index;
    logic [31:0] param_value;
    logic [31:0] grad_value;
    logic [32:0] d1;
    logic [32:0] d2;
  } elem_item_t;

  // Updated moments handed to the scaling unit
  typedef struct packed {
    logic        vld;
    logic [11:0] idx;
    logic [31:0] p;
    logic [31:0] m;
    logic [47:0] v;
    logic [32:0] d1;
    logic [32:0] d2;
  } moment_out_t;

endpackage
`default_nettype wire

>>> src/adp_front.sv
// Front end: config registers, item accept and classify, running beta powers.
`default_nettype none
module adp_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [adp_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                          s_tuser,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [adp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [adp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          clearing,
  input  wire logic                          q_full,
  output logic                               push,
  output adp_pkg::elem_item_t                push_item,
  output adp_pkg::cfg_t                      cfg
);

  logic [32:0] pow1;
  logic [32:0] pow2;
  logic [48:0] pow1_prod;
  logic [48:0] pow2_prod;
  logic        accept;
  logic        is_elem;

  assign cfg_ready = 1'b1;
  assign s_tready  = !clearing && !q_full;
  assign accept    = s_tvalid && s_tready;
  assign is_elem   = (adp_pkg::func_t'(s_tuser) == adp_pkg::FUNC_ELEM);
  assign push      = accept && is_elem;

  assign pow1_prod = pow1 * cfg.decay_first;
  assign pow2_prod = pow2 * cfg.decay_second;

  always_comb begin
    push_item.elem_index  = s_tdata[11:0];
    push_item.param_value = s_tdata[43:12];
    push_item.grad_value  = s_tdata[75:44];
    push_item.d1          = adp_pkg::ONE_Q32 - pow1;
    push_item.d2          = adp_pkg::ONE_Q32 - pow2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learn_rate   <= 24'd16777;
      cfg.decay_first  <= 16'd58982;
      cfg.decay_second <= 16'd65470;
      cfg.epsilon_term <= 16'd43;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        adp_pkg::REG_LEARN_RATE:   cfg.learn_rate   <= cfg_data;
        adp_pkg::REG_DECAY_FIRST:  cfg.decay_first  <= cfg_data[15:0];
        adp_pkg::REG_DECAY_SECOND: cfg.decay_second <= cfg_data[15:0];
        adp_pkg::REG_EPSILON:      cfg.epsilon_term <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Begin-step item: scale the running powers
  always_ff @(posedge clk) begin
    if (rst) begin
      pow1 <= adp_pkg::ONE_Q32;
      pow2 <= adp_pkg::ONE_Q32;
    end else if (accept && !is_elem) begin
      pow1 <= pow1_prod[48:16];
      pow2 <= pow2_prod[48:16];
    end
  end

endmodule
`default_nettype wire

>>> src/adp_queue.sv
// Short queue of element items between front end and moment stage.
`default_nettype none
module adp_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire adp_pkg::elem_item_t push_item,
  input  wire logic                pop,
  output logic                     q_valid,
  output adp_pkg::elem_item_t      q_item,
  output logic                     full
);

  adp_pkg::elem_item_t             entries [adp_pkg::QUEUE_DEPTH];
  logic [adp_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [adp_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [adp_pkg::QUEUE_PTR_W:0]   count;

  assign q_valid = (count != '0);
  assign full    = (count == (adp_pkg::QUEUE_PTR_W+1)'(adp_pkg::QUEUE_DEPTH));
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> src/adp_moment.sv
// Moment store with clearing pass and first/second moment update pipeline.
`default_nettype none
module adp_moment (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire adp_pkg::cfg_t       cfg,
  input  wire logic                q_valid,
  input  wire adp_pkg::elem_item_t q_item,
  input  wire logic                adv,
  output logic                     pop,
  output logic                     clearing,
  output adp_pkg::moment_out_t     mo
);

  typedef struct packed {
    logic        vld;
    logic [11:0] idx;
    logic [31:0] p;
    logic [31:0] g;
    logic [32:0] d1;
    logic [32:0] d2;
  } p0_t;

  typedef struct packed {
    logic        vld;
    logic [11:0] idx;
    logic [31:0] p;
    logic [49:0] pg1;
    logic [63:0] sq;
    logic [32:0] d1;
    logic [32:0] d2;
  } p1_t;

  typedef struct packed {
    logic        vld;
    logic [11:0] idx;
    logic [31:0] p;
    logic [49:0] pg1;
    logic [64:0] pv2;
    logic [32:0] d1;
    logic [32:0] d2;
  } p2_t;

  logic [79:0] mem [adp_pkg::ELEMENTS];
  logic [79:0] ram_q;

  p0_t p0;
  p1_t p1;
  p2_t p2;

  logic [adp_pkg::IDX_W-1:0] clr_addr;
  logic                      prev_vld;
  logic [adp_pkg::IDX_W-1:0] prev_addr;
  logic [31:0]               prev_m;
  logic [47:0]               prev_v;

  logic [16:0]               c1;
  logic [16:0]               c2;
  logic signed [49:0]        pg1_c;
  logic [31:0]               ag;
  logic [63:0]               sq_c;
  logic [64:0]               pv2_c;
  logic [adp_pkg::IDX_W-1:0] p1_addr;
  logic [adp_pkg::IDX_W-1:0] p2_addr;
  logic                      fwd;
  logic [31:0]               m_old;
  logic [47:0]               v_old;
  logic signed [50:0]        msum;
  logic [65:0]               vsum;
  logic [31:0]               m_new;
  logic [47:0]               v_new;

  assign pop = adv && q_valid && !clearing;

  assign c1 = 17'h10000 - {1'b0, cfg.decay_first};
  assign c2 = 17'h10000 - {1'b0, cfg.decay_second};

  // P0: gradient terms
  assign pg1_c = $signed({1'b0, c1}) * $signed(p0.g);
  assign ag    = p0.g[31] ? (32'd0 - p0.g) : p0.g;
  assign sq_c  = ag * ag;

  // P1: second moment gradient term
  assign pv2_c   = c2 * p1.sq[63:16];
  assign p1_addr = p1.idx[adp_pkg::IDX_W-1:0];
  assign p2_addr = p2.idx[adp_pkg::IDX_W-1:0];

  // P2: read-modify-write, take the last written entry when it matches
  assign fwd   = prev_vld && (prev_addr == p2_addr);
  assign m_old = fwd ? prev_m : ram_q[79:48];
  assign v_old = fwd ? prev_v : ram_q[47:0];
  assign msum  = $signed({1'b0, cfg.decay_first}) * $signed(m_old) + $signed(p2.pg1);
  assign vsum  = cfg.decay_second * v_old + p2.pv2;
  assign m_new = msum[47:16];
  assign v_new = vsum[63:16];

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (adv && p2.vld) begin
      mem[p2_addr] <= {m_new, v_new};
    end
    if (adv) begin
      ram_q <= mem[p1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == adp_pkg::IDX_W'(adp_pkg::ELEMENTS - 1)) clearing <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0.vld   <= 1'b0;
      p1.vld   <= 1'b0;
      p2.vld   <= 1'b0;
      mo.vld   <= 1'b0;
      prev_vld <= 1'b0;
    end else if (adv) begin
      p0.vld <= pop;
      p0.idx <= q_item.elem_index;
      p0.p   <= q_item.param_value;
      p0.g   <= q_item.grad_value;
      p0.d1  <= q_item.d1;
      p0.d2  <= q_item.d2;

      p1.vld <= p0.vld;
      p1.idx <= p0.idx;
      p1.p   <= p0.p;
      p1.pg1 <= pg1_c;
      p1.sq  <= sq_c;
      p1.d1  <= p0.d1;
      p1.d2  <= p0.d2;

      p2.vld <= p1.vld;
      p2.idx <= p1.idx;
      p2.p   <= p1.p;
      p2.pg1 <= p1.pg1;
      p2.pv2 <= pv2_c;
      p2.d1  <= p1.d1;
      p2.d2  <= p1.d2;

      prev_vld  <= p2.vld;
      prev_addr <= p2_addr;
      prev_m    <= m_new;
      prev_v    <= v_new;

      mo.vld <= p2.vld;
      mo.idx <= p2.idx;
      mo.p   <= p2.p;
      mo.m   <= m_new;
      mo.v   <= v_new;
      mo.d1  <= p2.d1;
      mo.d2  <= p2.d2;
    end
  end

endmodule
`default_nettype wire

>>> src/adp_scale.sv
// Bias correction, square root, step division and output register.
`default_nettype none
module adp_scale (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire adp_pkg::cfg_t                  cfg,
  input  wire adp_pkg::moment_out_t           mo,
  output logic                                adv,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [adp_pkg::OUT_DATA_W-1:0]      m_tdata
);

  typedef struct packed {
    logic        vld;
    logic [11:0] idx;
    logic [31:0] p;
    logic        neg;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [31:0] am;
    logic        z1;
    logic        s1;
    logic [32:0] d1;
    logic [32:0] r1;
    logic [31:0] w1;
    logic [47:0] v;
    logic        z2;
    logic        s2;
    logic [32:0] d2;
    logic [32:0] r2;
    logic [63:0] w2;
  } div_t;

  typedef struct packed {
    tag_t        tag;
    logic [30:0] mhm;
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] w;
  } sq_t;

  typedef struct packed {
    tag_t        tag;
    logic [48:0] den;
    logic [54:0] prod;
  } mul_t;

  typedef struct packed {
    tag_t        tag;
    logic        z3;
    logic        s3;
    logic [48:0] den;
    logic [48:0] r3;
    logic [33:0] w3;
  } qd_t;

  function automatic logic [33:0] div_step33(logic [32:0] r, logic b, logic [32:0] d);
    logic [33:0] t;
    logic [33:0] u;
    t = {r, b};
    u = t - {1'b0, d};
    if (t >= {1'b0, d}) return {1'b1, u[32:0]};
    else return {1'b0, t[32:0]};
  endfunction

  function automatic logic [49:0] div_step49(logic [48:0] r, logic b, logic [48:0] d);
    logic [49:0] t;
    logic [49:0] u;
    t = {r, b};
    u = t - {1'b0, d};
    if (t >= {1'b0, d}) return {1'b1, u[48:0]};
    else return {1'b0, t[48:0]};
  endfunction

  function automatic div_t dstep(div_t x);
    div_t        y;
    logic [33:0] o;
    y = x;
    for (int i = 0; i < 2; i++) begin
      o    = div_step33(y.r1, y.w1[31], y.d1);
      y.r1 = o[32:0];
      y.w1 = {y.w1[30:0], o[33]};
    end
    for (int i = 0; i < 4; i++) begin
      o    = div_step33(y.r2, y.w2[63], y.d2);
      y.r2 = o[32:0];
      y.w2 = {y.w2[62:0], o[33]};
    end
    return y;
  endfunction

  function automatic sq_t sstep(sq_t x);
    sq_t         y;
    logic [35:0] t;
    logic [35:0] trial;
    y = x;
    for (int i = 0; i < 2; i++) begin
      t     = {y.rem[33:0], y.w[63:62]};
      trial = {2'b00, y.root, 2'b01};
      y.w   = {y.w[61:0], 2'b00};
      if (t >= trial) begin
        y.rem  = t - trial;
        y.root = {y.root[30:0], 1'b1};
      end else begin
        y.rem  = t;
        y.root = {y.root[30:0], 1'b0};
      end
    end
    return y;
  endfunction

  function automatic qd_t qstep(qd_t x);
    qd_t         y;
    logic [49:0] o;
    y = x;
    for (int i = 0; i < 2; i++) begin
      o    = div_step49(y.r3, y.w3[33], y.den);
      y.r3 = o[48:0];
      y.w3 = {y.w3[32:0], o[49]};
    end
    return y;
  endfunction

  div_t dA;
  div_t dst [adp_pkg::DIV_STAGES];
  sq_t  sA;
  sq_t  sst [adp_pkg::SQRT_STAGES];
  mul_t m1;
  qd_t  qA;
  qd_t  qst [adp_pkg::QUO_STAGES];

  div_t        d_init;
  sq_t         s_init;
  mul_t        m_init;
  qd_t         q_init;
  div_t        dl;
  sq_t         sl;
  qd_t         ql;
  logic [62:0] numer;
  logic [33:0] um;
  logic [35:0] pe;
  logic [35:0] res36;
  logic [31:0] res;

  assign adv = !m_tvalid || m_tready;

  // Moments in: magnitude, saturation checks, divider start
  always_comb begin
    d_init.tag.vld = mo.vld;
    d_init.tag.idx = mo.idx;
    d_init.tag.p   = mo.p;
    d_init.tag.neg = mo.m[31];
    d_init.am      = mo.m[31] ? (32'd0 - mo.m) : mo.m;
    d_init.z1      = (mo.d1 == '0);
    d_init.s1      = !d_init.z1 && ({d_init.am, 1'b0} >= mo.d1);
    d_init.d1      = mo.d1;
    d_init.r1      = {1'b0, d_init.am};
    d_init.w1      = '0;
    d_init.v       = mo.v;
    d_init.z2      = (mo.d2 == '0);
    d_init.s2      = !d_init.z2 && ({17'd0, mo.v} >= {mo.d2, 32'd0});
    d_init.d2      = mo.d2;
    d_init.r2      = {17'd0, mo.v[47:32]};
    d_init.w2      = {mo.v[31:0], 32'd0};
  end

  // Corrected moments into the root unit
  assign dl = dst[adp_pkg::DIV_STAGES-1];
  always_comb begin
    s_init.tag = dl.tag;
    if (dl.z1)      s_init.mhm = dl.am[31] ? 31'h7FFF_FFFF : dl.am[30:0];
    else if (dl.s1) s_init.mhm = 31'h7FFF_FFFF;
    else            s_init.mhm = dl.w1[30:0];
    if (dl.z2)      s_init.w = {16'd0, dl.v};
    else if (dl.s2) s_init.w = '1;
    else            s_init.w = dl.w2;
    s_init.rem  = '0;
    s_init.root = '0;
  end

  assign sl = sst[adp_pkg::SQRT_STAGES-1];
  always_comb begin
    m_init.tag  = sl.tag;
    m_init.den  = {1'b0, sl.root, 16'd0} + {33'd0, cfg.epsilon_term};
    m_init.prod = cfg.learn_rate * sl.mhm;
  end

  assign numer = {m1.prod, 8'd0};
  always_comb begin
    q_init.tag = m1.tag;
    q_init.z3  = (m1.den == '0);
    q_init.s3  = ({20'd0, numer} >= {m1.den, 34'd0});
    q_init.den = m1.den;
    q_init.r3  = {20'd0, numer[62:34]};
    q_init.w3  = numer[33:0];
  end

  // Final update: clamp, apply sign, saturate
  assign ql = qst[adp_pkg::QUO_STAGES-1];
  always_comb begin
    if (ql.z3)                           um = '0;
    else if (ql.s3 || ql.w3 > 34'h2_0000_0000) um = 34'h2_0000_0000;
    else                                 um = ql.w3;
    pe    = {{4{ql.tag.p[31]}}, ql.tag.p};
    res36 = ql.tag.neg ? (pe + {2'b00, um}) : (pe - {2'b00, um});
    if (res36[35:31] == 5'b00000 || res36[35:31] == 5'b11111) res = res36[31:0];
    else if (res36[35])                                       res = 32'h8000_0000;
    else                                                      res = 32'h7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dA.tag.vld <= 1'b0;
      for (int k = 0; k < adp_pkg::DIV_STAGES; k++) dst[k].tag.vld <= 1'b0;
      sA.tag.vld <= 1'b0;
      for (int k = 0; k < adp_pkg::SQRT_STAGES; k++) sst[k].tag.vld <= 1'b0;
      m1.tag.vld <= 1'b0;
      qA.tag.vld <= 1'b0;
      for (int k = 0; k < adp_pkg::QUO_STAGES; k++) qst[k].tag.vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      dA     <= d_init;
      dst[0] <= dstep(dA);
      for (int k = 1; k < adp_pkg::DIV_STAGES; k++) dst[k] <= dstep(dst[k-1]);
      sA     <= s_init;
      sst[0] <= sstep(sA);
      for (int k = 1; k < adp_pkg::SQRT_STAGES; k++) sst[k] <= sstep(sst[k-1]);
      m1     <= m_init;
      qA     <= q_init;
      qst[0] <= qstep(qA);
      for (int k = 1; k < adp_pkg::QUO_STAGES; k++) qst[k] <= qstep(qst[k-1]);
      m_tvalid <= ql.tag.vld;
      m_tdata  <= {4'd0, res, ql.tag.idx};
    end
  end

endmodule
`default_nettype wire

>>> src/adam_parameter_update.sv
// Top level of the Adam parameter update engine.
//
//  channel  direction  signals                                   carries
//  s_*      in         s_tvalid s_tready s_tdata[79:0] s_tuser   begin-step / element items
//  m_*      out        m_tvalid m_tready m_tdata[47:0]           updated parameters
//  cfg_*    in         cfg_valid cfg_ready cfg_index cfg_data    register writes
//
// One item per cycle sustained while clearing is done and m_tready stays high; an element
// result passes the pipelined bias-correction dividers, root and step divider.
// Reset starts a clearing pass over all 4096 moment store entries; s_tready stays
// low until it ends, config writes are taken throughout.
// A stalled m_tready freezes the back pipeline; the item queue keeps s_tready
// high until it fills.
`default_nettype none
module adam_parameter_update (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // elem_index[11:0], param_value[43:12], grad_value[75:44]
  input  wire logic        s_tuser,   // func[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // elem_echo[11:0], new_param[43:12]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  adp_pkg::cfg_t        cfg;
  adp_pkg::elem_item_t  push_item;
  adp_pkg::elem_item_t  q_item;
  adp_pkg::moment_out_t mo;
  logic                 push;
  logic                 pop;
  logic                 q_valid;
  logic                 q_full;
  logic                 clearing;
  logic                 adv;

  adp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  adp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .full      (q_full)
  );

  adp_moment u_moment (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .adv      (adv),
    .pop      (pop),
    .clearing (clearing),
    .mo       (mo)
  );

  adp_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mo       (mo),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

>>> bench/tb_adam_parameter_update.sv
// Self-checking bench for the fixed-point Adam parameter update engine.
`default_nettype none
module tb_adam_parameter_update;

  localparam logic [7:0] REG_UNMAPPED = 8'd200;  // index with no register behind it
  localparam int SETTLE_CYCLES = 120;            // beyond the result latency

  typedef struct {
    adp_pkg::func_t func;
    logic [11:0]    idx;
    logic [31:0]    p;
    logic [31:0]    g;
  } upd_item_t;

  typedef struct {
    logic [11:0] idx;
    logic [31:0] p;
  } new_param_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // elem_index[11:0], param_value[43:12], grad_value[75:44]
  logic        s_tuser = 1'b0; // func[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // elem_echo[11:0], new_param[43:12]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  always #1 clk = ~clk;

  adam_parameter_update u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state
  logic [23:0]       lr = 24'd16777;
  logic [15:0]       beta1 = 16'd58982;
  logic [15:0]       beta2 = 16'd65470;
  logic [15:0]       eps = 16'd43;
  logic signed [31:0] m_store [adp_pkg::ELEMENTS];
  logic [47:0]       v_store [adp_pkg::ELEMENTS];
  longint unsigned   pow1 = 64'h1_0000_0000;
  longint unsigned   pow2 = 64'h1_0000_0000;

  upd_item_t  send_queue[$];
  new_param_t expected_params[$];
  int errors = 0;
  int results_checked = 0;
  int elems_sent = 0;
  int steps_sent = 0;
  int hold_gen = 0;
  int hold_len = 0;

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Apply one accepted item to the predictor, queue the parameter it should produce.
  function automatic void apply_update(input upd_item_t it);
    longint          p, g, m, res, upd;
    longint unsigned ag, g2, v, d1, d2, am, mhm, vh, q, r, s, den, um;
    logic            neg;
    int unsigned     ix;
    new_param_t      e;
    if (it.func == adp_pkg::FUNC_STEP) begin
      pow1 = (pow1 * beta1) >> 16;
      pow2 = (pow2 * beta2) >> 16;
      return;
    end
    ix = it.idx % adp_pkg::ELEMENTS;
    p = longint'($signed(it.p));
    g = longint'($signed(it.g));
    m = (longint'(beta1) * longint'(m_store[ix]) + longint'(65536 - beta1) * g) >>> 16;
    m_store[ix] = m[31:0];
    ag = (g < 0) ? -g : g;
    g2 = (ag * ag) >> 16;
    v = (longint'(beta2) * v_store[ix] + longint'(65536 - beta2) * g2) >> 16;
    v &= 64'hFFFF_FFFF_FFFF;
    v_store[ix] = v[47:0];
    d1 = 64'h1_0000_0000 - pow1;
    d2 = 64'h1_0000_0000 - pow2;
    neg = (m < 0);
    am = neg ? -m : m;
    mhm = (d1 == 0) ? am : ((am << 32) / d1);
    if (mhm > 64'h7FFF_FFFF) mhm = 64'h7FFF_FFFF;
    if (d2 == 0) vh = v;
    else begin
      q = v / d2;
      r = v % d2;
      vh = (q >= 64'h1_0000_0000) ? 64'hFFFF_FFFF_FFFF_FFFF : (q << 32) + ((r << 32) / d2);
    end
    s = floor_root(vh);
    den = (s << 16) + eps;
    if (den == 0) um = 0;
    else begin
      um = (longint'(lr) * mhm * 256) / den;
      if (um > 64'h2_0000_0000) um = 64'h2_0000_0000;
    end
    upd = neg ? -longint'(um) : longint'(um);
    res = p - upd;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    e.idx = it.idx;
    e.p = res[31:0];
    expected_params.push_back(e);
  endfunction

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  upd_item_t cur;
  always @(posedge clk) begin
    upd_item_t nxt;
    logic      take;
    if (!rst) begin
      if (s_tvalid && s_tready) apply_update(cur);
      if (!s_tvalid || s_tready) begin
        take = 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (send_queue.size() > 0) begin
          take = 1'b1;
          nxt = send_queue.pop_front();
          cur <= nxt;
          s_tuser <= nxt.func;
          s_tdata <= {4'b0, nxt.g, nxt.p, nxt.idx};
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else burst_left <= burst_left - 1;
        end
        s_tvalid <= take;
      end
    end
  end

  // Long receiver hold-off, loaded whenever the stimulus bumps hold_gen
  int hold_seen = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_cnt <= hold_len;
    end else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // Receiver: stall mode is re-drawn each time rx_cycle[7:0] reaches 8'hFF
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  always @(posedge clk) begin
    new_param_t e;
    logic       go;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_checked++;
        if (expected_params.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result idx=%0d param=%h",
                                     m_tdata[11:0], m_tdata[43:12]);
        end else begin
          e = expected_params.pop_front();
          if (e.idx !== m_tdata[11:0] || e.p !== m_tdata[43:12]) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected idx=%0d param=%h, got idx=%0d param=%h",
                       e.idx, e.p, m_tdata[11:0], m_tdata[43:12]);
          end
        end
      end
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[7:0] == 8'hFF) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: go = 1'b1;
        1: go = ($urandom_range(0, 3) != 0);
        2: go = ($urandom_range(0, 3) == 0);
        default: go = rx_cycle[2];
      endcase
      m_tready <= go && (hold_cnt == 0) && (hold_gen == hold_seen);
    end
  end

  task automatic write_reg(input logic [7:0] ix, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (ix)
      adp_pkg::REG_LEARN_RATE:   lr = val;
      adp_pkg::REG_DECAY_FIRST:  beta1 = val[15:0];
      adp_pkg::REG_DECAY_SECOND: beta2 = val[15:0];
      adp_pkg::REG_EPSILON:      eps = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [23:0] a, input logic [15:0] b1,
                          input logic [15:0] b2, input logic [15:0] e);
    write_reg(adp_pkg::REG_LEARN_RATE, a);
    write_reg(adp_pkg::REG_DECAY_FIRST, {8'd0, b1});
    write_reg(adp_pkg::REG_DECAY_SECOND, {8'd0, b2});
    write_reg(adp_pkg::REG_EPSILON, {8'd0, e});
  endtask

  task automatic push_item(input adp_pkg::func_t f, input logic [11:0] ix,
                           input logic [31:0] p, input logic [31:0] g);
    upd_item_t it;
    it.func = f;
    it.idx = ix;
    it.p = p;
    it.g = g;
    send_queue.push_back(it);
    if (f == adp_pkg::FUNC_STEP) steps_sent++;
    else elems_sent++;
  endtask

  function automatic logic [31:0] rand_q824();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2: return $urandom;
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  // Mostly element items on a small working set, with occasional step items
  task automatic push_random(input int count);
    logic [11:0] ix;
    for (int k = 0; k < count; k++) begin
      ix = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 31));
      if ($urandom_range(0, 15) == 0) push_item(adp_pkg::FUNC_STEP, ix, $urandom, $urandom);
      else push_item(adp_pkg::FUNC_ELEM, ix, rand_q824(), rand_q824());
    end
  endtask

  task automatic drain();
    while (send_queue.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_params.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < adp_pkg::ELEMENTS; i++) begin
      m_store[i] = '0;
      v_store[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Elements before any step (no bias correction yet), then after the first steps; field extremes
    push_item(adp_pkg::FUNC_ELEM, 12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_item(adp_pkg::FUNC_ELEM, 12'd4095, 32'h8000_0000, 32'h8000_0000);
    push_item(adp_pkg::FUNC_ELEM, 12'd1, 32'h0, 32'h0);
    push_item(adp_pkg::FUNC_ELEM, 12'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    push_item(adp_pkg::FUNC_ELEM, 12'd2730, 32'hFFFF_FFFF, 32'h0100_0000);
    push_item(adp_pkg::FUNC_STEP, 12'd1365, 32'h5555_5555, 32'hAAAA_AAAA);
    push_item(adp_pkg::FUNC_ELEM, 12'd4095, 32'h7FFF_FFFF, 32'hFF00_0000);
    push_item(adp_pkg::FUNC_ELEM, 12'd1365, 32'h0000_0001, 32'hFFFF_FFFF);
    push_item(adp_pkg::FUNC_STEP, 12'd0, 32'h0, 32'h0);
    push_item(adp_pkg::FUNC_ELEM, 12'd0, 32'h8000_0000, 32'h8000_0000);
    push_item(adp_pkg::FUNC_ELEM, 12'd3, 32'h0100_0000, 32'h0000_0100);
    push_random(60);
    // Let the clearing pass finish and the first items come back
    drain();
    // Stop draining the output so the input side backs up
    hold_len = 400;
    hold_gen++;
    push_random(400);
    drain();

    // Extremes: max rate, zero decays, no epsilon; zero denominator on tiny gradients
    set_regs(24'hFF_FFFF, 16'd0, 16'd0, 16'd0);
    push_item(adp_pkg::FUNC_ELEM, 12'd5, 32'h0100_0000, 32'h0);
    push_item(adp_pkg::FUNC_ELEM, 12'd6, 32'h0100_0000, 32'h0000_00FF);
    push_item(adp_pkg::FUNC_STEP, 12'd0, 32'h0, 32'h0);
    push_item(adp_pkg::FUNC_ELEM, 12'd7, 32'h8000_0000, 32'hFFFF_FF01);
    push_item(adp_pkg::FUNC_ELEM, 12'd8, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_random(400);
    drain();

    // Opposite extremes plus a write to an unmapped index
    set_regs(24'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_UNMAPPED, 24'hABCDEF);
    push_random(200);
    drain();
    set_regs(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    push_random(200);
    drain();

    set_regs(24'($urandom), 16'($urandom), 16'($urandom_range(60000, 65535)), 16'($urandom));
    push_random(450);
    drain();

    $display("covered %0d element and %0d step items over five register settings,",
             elems_sent, steps_sent);
    $display("checked %0d updated parameters including a %0d-cycle output hold-off",
             results_checked, hold_len);
    if (errors == 0 && expected_params.size() == 0) begin
      $display("PASS adam_parameter_update");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, expected_params.size());
      $display("FAIL adam_parameter_update");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_params.size());
    $display("FAIL adam_parameter_update");
    $finish;
  end

endmodule
`default_nettype wire

>>> adam_parameter_update.f
src/adp_pkg.sv
src/adp_front.sv
src/adp_queue.sv
src/adp_moment.sv
src/adp_scale.sv
src/adam_parameter_update.sv
bench/tb_adam_parameter_update.sv
